FILE: sv/gcvt_pkg.sv
// Package for the blob space and GC victim table: field widths, command,
// status and register codes, and the table entry and write request types.
// No dependencies; every other file of the block uses it.
`default_nettype none
package gcvt_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 32;

  localparam int unsigned IdW    = 32;
  localparam int unsigned SizeW  = 42;
  localparam int unsigned MaxW   = 40;
  localparam int unsigned ThrW   = 17;
  localparam int unsigned HdrW   = 8;
  localparam int unsigned KeyW   = 16;
  localparam int unsigned ValW   = 32;
  localparam int unsigned GbW    = 40;
  localparam int unsigned OffW   = 41;
  localparam int unsigned RecW   = 33;
  localparam int unsigned HalfW  = 21;
  localparam int unsigned ProdW  = SizeW + HalfW;
  localparam int unsigned CrossW = 2 * SizeW;

  localparam logic [MaxW-1:0] MaxSizeReset = 40'd268435456;
  localparam logic [ThrW-1:0] ThrReset     = 17'd32768;
  localparam logic [HdrW-1:0] HdrReset     = 8'd12;

  typedef enum logic [1:0] {
    CMD_APPEND = 2'd0,
    CMD_NOTICE = 2'd1,
    CMD_PICK   = 2'd2,
    CMD_RETIRE = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_UNKNOWN  = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOVICTIM = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    REG_MAX_SIZE = 2'd0,
    REG_THRESH   = 2'd1,
    REG_HEADER   = 2'd2,
    REG_NONE     = 2'd3
  } reg_e;

  typedef struct packed {
    logic [IdW-1:0]   id;
    logic [SizeW-1:0] size;
    logic [SizeW-1:0] garbage;
  } entry_t;

  typedef struct packed {
    logic   we;
    logic   set_valid;
    logic   clr_valid;
    entry_t entry;
  } tbl_wr_t;

  typedef struct packed {
    logic [MaxW-1:0] max_size;
    logic [ThrW-1:0] thresh;
    logic [HdrW-1:0] header;
  } cfg_t;

endpackage
`default_nettype wire

FILE: sv/gcvt_table.sv
// File table storage: a synchronous entry memory with registered reads,
// per-entry valid flags and a lowest-free-slot search.
// Depends on gcvt_pkg.
`default_nettype none
module gcvt_table #(
  parameter int unsigned TABLE_DEPTH = gcvt_pkg::TABLE_DEPTH_DEF,
  localparam int unsigned IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire gcvt_pkg::tbl_wr_t wr_i,
  input  wire  [IdxW-1:0]       wr_addr_i,
  input  wire  [IdxW-1:0]       rd_addr_i,
  output gcvt_pkg::entry_t      rd_entry_o,
  output logic [TABLE_DEPTH-1:0] valid_o,
  output logic                  free_any_o,
  output logic [IdxW-1:0]       free_idx_o
);

  gcvt_pkg::entry_t mem [TABLE_DEPTH];
  gcvt_pkg::entry_t rd_q;
  logic [TABLE_DEPTH-1:0] valid_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem[wr_addr_i] <= wr_i.entry;
    end
    rd_q <= mem[rd_addr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_i.set_valid) begin
      valid_q[wr_addr_i] <= 1'b1;
    end else if (wr_i.clr_valid) begin
      valid_q[wr_addr_i] <= 1'b0;
    end
  end

  always_comb begin
    free_any_o = 1'b0;
    free_idx_o = '0;
    for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_any_o = 1'b1;
        free_idx_o = IdxW'(i);
      end
    end
  end

  assign rd_entry_o = rd_q;
  assign valid_o    = valid_q;

endmodule
`default_nettype wire

FILE: sv/gcvt_cfg.sv
// Configuration registers behind an APB-style port with 64-bit data.
// Depends on gcvt_pkg.
`default_nettype none
module gcvt_cfg (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            psel,
  input  wire            penable,
  input  wire            pwrite,
  input  wire  [4:0]     paddr,
  input  wire  [63:0]    pwdata,
  output logic [63:0]    prdata,
  output logic           pready,
  output gcvt_pkg::cfg_t cfg_o
);

  gcvt_pkg::cfg_t cfg_q;
  gcvt_pkg::reg_e sel;

  assign sel    = gcvt_pkg::reg_e'(paddr[4:3]);
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_size <= gcvt_pkg::MaxSizeReset;
      cfg_q.thresh   <= gcvt_pkg::ThrReset;
      cfg_q.header   <= gcvt_pkg::HdrReset;
    end else if (psel && penable && pwrite) begin
      case (sel)
        gcvt_pkg::REG_MAX_SIZE: cfg_q.max_size <= pwdata[gcvt_pkg::MaxW-1:0];
        gcvt_pkg::REG_THRESH:   cfg_q.thresh   <= pwdata[gcvt_pkg::ThrW-1:0];
        gcvt_pkg::REG_HEADER:   cfg_q.header   <= pwdata[gcvt_pkg::HdrW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (sel)
      gcvt_pkg::REG_MAX_SIZE: prdata = 64'(cfg_q.max_size);
      gcvt_pkg::REG_THRESH:   prdata = 64'(cfg_q.thresh);
      gcvt_pkg::REG_HEADER:   prdata = 64'(cfg_q.header);
      default:                prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

FILE: sv/blob_space_and_gc_victim_table_top.sv
// Top level: command sequencer, open-file state, shared multiplier and
// result register around the file table and configuration registers.
// Depends on gcvt_pkg, gcvt_table and gcvt_cfg.
//
// One command is handled at a time. An append that needs no table change
// goes straight to the update state; closing a file, a garbage notice and
// a retire scan the table entry by entry. A pick reads every entry and,
// for each qualifying entry after the first, forms the 84-bit cross
// products through one registered 42x21 multiplier. A stalled result
// beat holds the sequencer until it leaves. The table has no clearing
// pass; its valid flags clear at reset.
`default_nettype none
module blob_space_and_gc_victim_table_top #(
  parameter int unsigned TABLE_DEPTH = gcvt_pkg::TABLE_DEPTH_DEF
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [4:0]  paddr,
  input  wire  [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  input  wire         in_valid_i,
  output logic        in_stall_o,
  input  wire  [1:0]  cmd_i,
  input  wire  [15:0] key_length_i,
  input  wire  [31:0] value_length_i,
  input  wire  [31:0] target_file_i,
  input  wire  [39:0] garbage_bytes_i,
  output logic        out_valid_o,
  input  wire         out_stall_i,
  output logic [31:0] result_file_o,
  output logic [40:0] record_offset_o,
  output logic [32:0] record_bytes_o,
  output logic [1:0]  status_o
);

  localparam int unsigned IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(TABLE_DEPTH - 1);
  localparam int unsigned SW = gcvt_pkg::SizeW;
  localparam int unsigned HW = gcvt_pkg::HalfW;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_RD    = 11'b00000000010,
    S_CHK   = 11'b00000000100,
    S_THR   = 11'b00000001000,
    S_X1    = 11'b00000010000,
    S_X2    = 11'b00000100000,
    S_X3    = 11'b00001000000,
    S_X4    = 11'b00010000000,
    S_CMP   = 11'b00100000000,
    S_UPD   = 11'b01000000000,
    S_PDONE = 11'b10000000000
  } state_e;

  state_e state_q, state_d;

  gcvt_pkg::cfg_t    cfg;
  gcvt_pkg::tbl_wr_t wr;
  gcvt_pkg::entry_t  rd_entry;
  logic [IdxW-1:0]   wr_addr;
  logic [TABLE_DEPTH-1:0] valid_vec;
  logic              free_any;
  logic [IdxW-1:0]   free_idx;
  logic [IdxW-1:0]   idx_q, idx_d;

  gcvt_cfg u_cfg (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata,
    .prdata, .pready, .cfg_o(cfg)
  );

  gcvt_table #(.TABLE_DEPTH(TABLE_DEPTH)) u_table (
    .clk_i, .rst_ni, .wr_i(wr), .wr_addr_i(wr_addr), .rd_addr_i(idx_q),
    .rd_entry_o(rd_entry), .valid_o(valid_vec), .free_any_o(free_any),
    .free_idx_o(free_idx)
  );

  gcvt_pkg::cmd_e cmd_q;
  logic [15:0] key_q;
  logic [31:0] val_q;
  logic [31:0] target_q;
  logic [39:0] gb_q;
  logic        close_q, close_d;
  logic        newf_q, newf_d;

  logic        found_q, found_d;
  logic [IdxW-1:0] fidx_q, fidx_d;
  gcvt_pkg::entry_t fent_q, fent_d;

  logic [31:0] next_id_q, next_id_d;
  logic        file_open_q, file_open_d;
  logic [SW-1:0] open_bytes_q, open_bytes_d;

  logic [SW-1:0] n_q, n_d, d_q, d_d;
  logic [31:0]   eid_q, eid_d;
  logic          best_vld_q, best_vld_d;
  logic [31:0]   best_id_q, best_id_d;
  logic [SW-1:0] bn_q, bn_d, bd_q, bd_d;
  logic [gcvt_pkg::CrossW-1:0] accx_q, accx_d, accy_q, accy_d;

  logic [SW-1:0] mul_a;
  logic [HW-1:0] mul_b;
  logic [gcvt_pkg::ProdW-1:0] prod_q;

  logic        out_valid_q, out_valid_d;
  logic [31:0] res_file_q, res_file_d;
  logic [40:0] res_off_q, res_off_d;
  logic [32:0] res_bytes_q, res_bytes_d;
  gcvt_pkg::status_e res_stat_q, res_stat_d;

  logic        out_free;
  logic [31:0] open_id;
  logic [31:0] key_id;
  logic        in_acc;
  logic        thr_ok;
  logic        last;
  logic [32:0] rec;
  logic [42:0] gsum;
  logic [SW-1:0] gsat;
  logic [SW-1:0] base;

  assign out_free = !out_valid_q || !out_stall_i;
  assign open_id  = next_id_q - 32'd1;
  assign key_id   = (cmd_q == gcvt_pkg::CMD_APPEND) ? open_id : target_q;
  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc   = in_valid_i && !in_stall_o;
  assign last     = (idx_q == LastIdx);
  assign thr_ok   = !(prod_q < gcvt_pkg::ProdW'({n_q, 16'd0})) && (n_q < d_q);
  assign rec      = 33'(cfg.header) + 33'(key_q) + 33'(val_q);
  assign gsum     = 43'(fent_q.garbage) + 43'(gb_q);
  assign gsat     = (gsum > 43'(fent_q.size)) ? fent_q.size : gsum[SW-1:0];
  assign base     = newf_q ? '0 : open_bytes_q;

  always_ff @(posedge clk_i) begin
    prod_q <= gcvt_pkg::ProdW'(mul_a) * gcvt_pkg::ProdW'(mul_b);
    if (in_acc) begin
      cmd_q    <= gcvt_pkg::cmd_e'(cmd_i);
      key_q    <= key_length_i;
      val_q    <= value_length_i;
      target_q <= target_file_i;
      gb_q     <= garbage_bytes_i;
    end
    close_q  <= close_d;
    newf_q   <= newf_d;
    idx_q    <= idx_d;
    fidx_q   <= fidx_d;
    fent_q   <= fent_d;
    n_q      <= n_d;
    d_q      <= d_d;
    eid_q    <= eid_d;
    best_id_q <= best_id_d;
    bn_q     <= bn_d;
    bd_q     <= bd_d;
    accx_q   <= accx_d;
    accy_q   <= accy_d;
    res_file_q  <= res_file_d;
    res_off_q   <= res_off_d;
    res_bytes_q <= res_bytes_d;
    res_stat_q  <= res_stat_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      next_id_q    <= 32'd1;
      file_open_q  <= 1'b0;
      open_bytes_q <= '0;
      found_q      <= 1'b0;
      best_vld_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      next_id_q    <= next_id_d;
      file_open_q  <= file_open_d;
      open_bytes_q <= open_bytes_d;
      found_q      <= found_d;
      best_vld_q   <= best_vld_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_comb begin
    state_d = state_q;
    close_d = close_q;
    newf_d  = newf_q;
    idx_d   = idx_q;
    found_d = found_q;
    fidx_d  = fidx_q;
    fent_d  = fent_q;
    n_d     = n_q;
    d_d     = d_q;
    eid_d   = eid_q;
    best_vld_d = best_vld_q;
    best_id_d  = best_id_q;
    bn_d    = bn_q;
    bd_d    = bd_q;
    accx_d  = accx_q;
    accy_d  = accy_q;
    next_id_d    = next_id_q;
    file_open_d  = file_open_q;
    open_bytes_d = open_bytes_q;
    out_valid_d  = out_valid_q && out_stall_i;
    res_file_d  = res_file_q;
    res_off_d   = res_off_q;
    res_bytes_d = res_bytes_q;
    res_stat_d  = res_stat_q;
    mul_a = '0;
    mul_b = '0;
    wr      = '0;
    wr_addr = fidx_q;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          idx_d      = '0;
          found_d    = 1'b0;
          best_vld_d = 1'b0;
          newf_d  = !file_open_q || (open_bytes_q > SW'(cfg.max_size));
          close_d = file_open_q && (open_bytes_q > SW'(cfg.max_size));
          if (gcvt_pkg::cmd_e'(cmd_i) == gcvt_pkg::CMD_APPEND &&
              !(file_open_q && (open_bytes_q > SW'(cfg.max_size)))) begin
            state_d = S_UPD;
          end else begin
            state_d = S_RD;
          end
        end
      end
      S_RD: begin
        state_d = S_CHK;
      end
      S_CHK: begin
        eid_d = rd_entry.id;
        if (rd_entry.size == '0) begin
          n_d = '0;
          d_d = SW'(1);
        end else begin
          n_d = rd_entry.size - rd_entry.garbage;
          d_d = rd_entry.size;
        end
        mul_a = d_d;
        mul_b = HW'(cfg.thresh);
        if (cmd_q == gcvt_pkg::CMD_PICK) begin
          if (!valid_vec[idx_q] || (file_open_q && rd_entry.id == open_id)) begin
            if (last) begin
              state_d = S_PDONE;
            end else begin
              idx_d   = idx_q + 1'b1;
              state_d = S_RD;
            end
          end else begin
            state_d = S_THR;
          end
        end else if (valid_vec[idx_q] && rd_entry.id == key_id) begin
          found_d = 1'b1;
          fidx_d  = idx_q;
          fent_d  = rd_entry;
          state_d = S_UPD;
        end else if (last) begin
          state_d = S_UPD;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = S_RD;
        end
      end
      S_THR: begin
        mul_a = n_q;
        mul_b = bd_q[HW-1:0];
        if (thr_ok && best_vld_q) begin
          state_d = S_X1;
        end else begin
          if (thr_ok) begin
            best_vld_d = 1'b1;
            best_id_d  = eid_q;
            bn_d = n_q;
            bd_d = d_q;
          end
          if (last) begin
            state_d = S_PDONE;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = S_RD;
          end
        end
      end
      S_X1: begin
        mul_a  = n_q;
        mul_b  = bd_q[SW-1:HW];
        accx_d = gcvt_pkg::CrossW'(prod_q);
        state_d = S_X2;
      end
      S_X2: begin
        mul_a  = bn_q;
        mul_b  = d_q[HW-1:0];
        accx_d = accx_q + (gcvt_pkg::CrossW'(prod_q) << HW);
        state_d = S_X3;
      end
      S_X3: begin
        mul_a  = bn_q;
        mul_b  = d_q[SW-1:HW];
        accy_d = gcvt_pkg::CrossW'(prod_q);
        state_d = S_X4;
      end
      S_X4: begin
        accy_d = accy_q + (gcvt_pkg::CrossW'(prod_q) << HW);
        state_d = S_CMP;
      end
      S_CMP: begin
        if (accx_q < accy_q || (accx_q == accy_q && eid_q < best_id_q)) begin
          best_id_d = eid_q;
          bn_d = n_q;
          bd_d = d_q;
        end
        if (last) begin
          state_d = S_PDONE;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = S_RD;
        end
      end
      S_UPD: begin
        if (out_free) begin
          state_d     = S_IDLE;
          out_valid_d = 1'b1;
          res_file_d  = '0;
          res_off_d   = '0;
          res_bytes_d = '0;
          res_stat_d  = gcvt_pkg::ST_OK;
          case (cmd_q)
            gcvt_pkg::CMD_APPEND: begin
              if (close_q && !found_q && !free_any) begin
                res_stat_d = gcvt_pkg::ST_FULL;
              end else begin
                if (close_q) begin
                  wr.we            = 1'b1;
                  wr.set_valid     = 1'b1;
                  wr.entry.id      = open_id;
                  wr.entry.size    = open_bytes_q;
                  wr.entry.garbage = '0;
                  wr_addr          = found_q ? fidx_q : free_idx;
                end
                if (newf_q) begin
                  next_id_d   = next_id_q + 32'd1;
                  file_open_d = 1'b1;
                  res_file_d  = next_id_q;
                end else begin
                  res_file_d  = open_id;
                end
                res_off_d    = base[40:0];
                res_bytes_d  = rec;
                open_bytes_d = base + SW'(rec);
              end
            end
            gcvt_pkg::CMD_NOTICE: begin
              if (found_q) begin
                wr.we            = 1'b1;
                wr.entry.id      = fent_q.id;
                wr.entry.size    = fent_q.size;
                wr.entry.garbage = gsat;
              end else begin
                res_stat_d = gcvt_pkg::ST_UNKNOWN;
              end
            end
            gcvt_pkg::CMD_RETIRE: begin
              if (found_q) begin
                wr.clr_valid = 1'b1;
              end else begin
                res_stat_d = gcvt_pkg::ST_UNKNOWN;
              end
            end
            default: ;
          endcase
        end
      end
      S_PDONE: begin
        if (out_free) begin
          state_d     = S_IDLE;
          out_valid_d = 1'b1;
          res_off_d   = '0;
          res_bytes_d = '0;
          res_file_d  = best_vld_q ? best_id_q : '0;
          res_stat_d  = best_vld_q ? gcvt_pkg::ST_OK : gcvt_pkg::ST_NOVICTIM;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_o     = out_valid_q;
  assign result_file_o   = res_file_q;
  assign record_offset_o = res_off_q;
  assign record_bytes_o  = res_bytes_q;
  assign status_o        = res_stat_q;

`ifndef SYNTHESIS
  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("sequencer state is not one-hot");

  a_open_stays: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$fell(file_open_q)) else $error("open file flag dropped");

  a_garbage_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UPD && wr.we && cmd_q == gcvt_pkg::CMD_NOTICE)
      |-> (wr.entry.garbage <= wr.entry.size))
    else $error("garbage count exceeds file size");

  a_result_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_PDONE || state_q == S_UPD) && out_free) |=> out_valid_q)
    else $error("finished command produced no result beat");

  a_full_no_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UPD && out_free && cmd_q == gcvt_pkg::CMD_APPEND &&
     close_q && !found_q && !free_any) |=> $stable(next_id_q))
    else $error("refused append changed the file id");
`endif

endmodule
`default_nettype wire
